/* src/mbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  // Default build widths
  localparam int PIXEL_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_BITS_DEF  = 16;

  // Register reset values; origins and step are given at Q4.28 scale
  localparam longint MAX_ITER_RST = 1000;
  localparam longint ORG_RE_RST   = -805306368;  // -3.0
  localparam longint ORG_IM_RST   = -322122547;  // about -1.2
  localparam longint STEP_RST     = 2147484;     // about 0.008

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_ORG_RE   = 2'd1,
    REG_ORG_IM   = 2'd2,
    REG_STEP     = 2'd3
  } cfg_reg_t;

  // Clamp a reset constant into a signed word of the given width
  function automatic longint clamp_word(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/mbe_coord.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pixel to complex point: product stage, then origin add stage.
module mbe_coord #(
  parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         req_vld,
  input  wire        [PIXEL_BITS-1:0] req_x,
  input  wire        [PIXEL_BITS-1:0] req_y,
  output logic                        req_hold,
  input  wire signed [W-1:0]          org_re,
  input  wire signed [W-1:0]          org_im,
  input  wire        [FRAC_BITS-1:0]  step,
  output logic                        c_vld,
  output logic signed [W-1:0]         c_re,
  output logic signed [W-1:0]         c_im,
  input  wire                         c_take
);
  import mbe_pkg::*;

  localparam int PB = PIXEL_BITS + FRAC_BITS;
  localparam int XW = PB + W;
  localparam logic [XW-1:0] PMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic                  p_vld_r, q_vld_r, r_vld_r;
  logic [PIXEL_BITS-1:0] px_r, py_r;
  logic [W-2:0]          qx_r, qy_r;
  logic signed [W-1:0]   cre_r, cim_r;

  logic          r_ld, q_ld;
  logic [PB-1:0] prod_x, prod_y;
  logic [XW-1:0] ext_x, ext_y;
  logic [W-2:0]  sat_x, sat_y;
  logic [W:0]    sum_re, sum_im;
  logic signed [W-1:0] cre_nxt, cim_nxt;

  assign r_ld     = !r_vld_r || c_take;
  assign q_ld     = !q_vld_r || r_ld;
  assign req_hold = p_vld_r && !q_ld;

  always_comb begin
    prod_x = {{FRAC_BITS{1'b0}}, px_r} * {{PIXEL_BITS{1'b0}}, step};
    prod_y = {{FRAC_BITS{1'b0}}, py_r} * {{PIXEL_BITS{1'b0}}, step};
    ext_x  = {{W{1'b0}}, prod_x};
    ext_y  = {{W{1'b0}}, prod_y};
    sat_x  = (ext_x > PMAX) ? {(W-1){1'b1}} : ext_x[W-2:0];
    sat_y  = (ext_y > PMAX) ? {(W-1){1'b1}} : ext_y[W-2:0];
    sum_re = {org_re[W-1], org_re} + {2'b00, qx_r};
    sum_im = {org_im[W-1], org_im} + {2'b00, qy_r};
    if (sum_re[W] != sum_re[W-1]) cre_nxt = sum_re[W] ? WMIN : WMAX;
    else                          cre_nxt = sum_re[W-1:0];
    if (sum_im[W] != sum_im[W-1]) cim_nxt = sum_im[W] ? WMIN : WMAX;
    else                          cim_nxt = sum_im[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
    end else begin
      if (!req_hold) p_vld_r <= req_vld;
      if (q_ld) q_vld_r <= p_vld_r;
      if (r_ld) r_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_hold && req_vld) begin
      px_r <= req_x;
      py_r <= req_y;
    end
    if (q_ld) begin
      qx_r <= sat_x;
      qy_r <= sat_y;
    end
    if (r_ld) begin
      cre_r <= cre_nxt;
      cim_r <= cim_nxt;
    end
  end

  assign c_vld = r_vld_r;
  assign c_re  = cre_r;
  assign c_im  = cim_r;

endmodule

`default_nettype wire

/* src/mbe_ring.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-stage iteration ring: multiply, scale/saturate, add c and decide.
// Up to three pixels circulate; finished ones wait in the ring for their turn.
module mbe_ring #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS = mbe_pkg::ITER_BITS_DEF,
  localparam int W = FRAC_BITS + 4
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire        [ITER_BITS-1:0] max_iter,
  input  wire                        c_vld,
  input  wire signed [W-1:0]         c_re,
  input  wire signed [W-1:0]         c_im,
  output logic                       c_take,
  output logic                       res_vld,
  output logic       [ITER_BITS-1:0] res_cnt,
  output logic       [2:0]           res_pal
);
  import mbe_pkg::*;

  localparam int PW = 2 * W;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] FOUR = {{(PW-3){1'b0}}, 3'b100} << FRAC_BITS;

  typedef struct packed {
    logic                 vld;
    logic                 done;
    logic [1:0]           tag;
    logic [ITER_BITS-1:0] k;
    logic [2:0]           m7;
    logic [ITER_BITS-1:0] cnt;
    logic [2:0]           pal;
    logic signed [W-1:0]  zr;
    logic signed [W-1:0]  zi;
    logic signed [W-1:0]  cr;
    logic signed [W-1:0]  ci;
  } tok_t;

  tok_t s1_r, s2_r, s3_r, s1_nxt, back;
  logic signed [PW-1:0] prr_r, pii_r, pri_r;
  logic signed [W-1:0]  d_r, x_r;
  logic                 esc_r;
  logic [1:0]           in_seq_r, out_seq_r;

  logic signed [PW-1:0] rr, ii, ri, diff, mag;
  logic signed [W-1:0]  d_nxt, x_nxt, nr, ni;
  logic [W:0]           sr, si;
  logic                 fin, emit;
  logic [ITER_BITS-1:0] fcnt;
  logic [2:0]           fpal;

  // scale and saturate
  always_comb begin
    rr   = prr_r >>> FRAC_BITS;
    ii   = pii_r >>> FRAC_BITS;
    ri   = pri_r >>> (FRAC_BITS - 1);
    diff = rr - ii;
    mag  = rr + ii;
    if (diff[PW-1:W-1] != {(PW-W+1){diff[PW-1]}}) d_nxt = diff[PW-1] ? WMIN : WMAX;
    else                                           d_nxt = diff[W-1:0];
    if (ri[PW-1:W-1] != {(PW-W+1){ri[PW-1]}}) x_nxt = ri[PW-1] ? WMIN : WMAX;
    else                                       x_nxt = ri[W-1:0];
  end

  // add c, escape decision
  always_comb begin
    sr = {d_r[W-1], d_r} + {s3_r.cr[W-1], s3_r.cr};
    si = {x_r[W-1], x_r} + {s3_r.ci[W-1], s3_r.ci};
    if (sr[W] != sr[W-1]) nr = sr[W] ? WMIN : WMAX;
    else                  nr = sr[W-1:0];
    if (si[W] != si[W-1]) ni = si[W] ? WMIN : WMAX;
    else                  ni = si[W-1:0];

    back = s3_r;
    fin  = 1'b1;
    fcnt = s3_r.cnt;
    fpal = s3_r.pal;
    if (!s3_r.done) begin
      if (s3_r.k != '0 && esc_r) begin
        // escaped on the previous update
        fcnt = s3_r.k - 1'b1;
        fpal = (s3_r.m7 == 3'd0) ? 3'd6 : s3_r.m7 - 3'd1;
      end else if (s3_r.k == max_iter) begin
        fcnt = s3_r.k;
        fpal = s3_r.m7;
      end else begin
        fin     = 1'b0;
        back.zr = nr;
        back.zi = ni;
        back.k  = s3_r.k + 1'b1;
        back.m7 = (s3_r.m7 == 3'd6) ? 3'd0 : s3_r.m7 + 3'd1;
      end
    end
    back.done = fin;
    back.cnt  = fcnt;
    back.pal  = fpal;
    emit      = s3_r.vld && fin && (s3_r.tag == out_seq_r);
    back.vld  = s3_r.vld && !emit;

    c_take = c_vld && !back.vld;
    if (c_take) begin
      s1_nxt      = '0;
      s1_nxt.vld  = 1'b1;
      s1_nxt.tag  = in_seq_r;
      s1_nxt.cr   = c_re;
      s1_nxt.ci   = c_im;
    end else begin
      s1_nxt = back;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_r      <= '0;
      s3_r      <= '0;
      in_seq_r  <= '0;
      out_seq_r <= '0;
      res_vld   <= 1'b0;
    end else begin
      s1_r    <= s1_nxt;
      s2_r    <= s1_r;
      s3_r    <= s2_r;
      res_vld <= emit;
      if (c_take) in_seq_r <= in_seq_r + 2'd1;
      if (emit) out_seq_r <= out_seq_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    prr_r <= s1_r.zr * s1_r.zr;
    pii_r <= s1_r.zi * s1_r.zi;
    pri_r <= s1_r.zr * s1_r.zi;
    d_r   <= d_nxt;
    x_r   <= x_nxt;
    esc_r <= (mag > $signed(FOUR));
    if (emit) begin
      res_cnt <= fcnt;
      res_pal <= fpal;
    end
  end

endmodule

`default_nettype wire

/* src/mandelbrot_escape_time.sv */
`timescale 1ns / 1ps
`default_nettype none

// Mandelbrot escape-time unit. A pixel request (in_pixel_x, in_pixel_y) is
// taken at a clock edge where start is high and busy is low. The pixel is
// mapped to c = origin + pixel*step_size, then z = z^2 + c is iterated in a
// three-stage ring (multiply, scale/saturate, add c and escape test). A pixel
// that makes n updates (count+1 when it escapes, count when it hits the
// limit) passes the ring n+1 times. Up to three pixels share the ring, each
// in its own slot, so a new pixel can enter a free slot while others still
// iterate. Results leave in request order as a one-cycle out_strobe pulse
// with out_iteration_count and out_palette_index; the receiver cannot stall
// them. Write cfg_* registers only while no request is in flight.
module mandelbrot_escape_time #(
  parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbe_pkg::ITER_BITS_DEF,
  localparam int W  = FRAC_BITS + 4,
  localparam int CW = (ITER_BITS > W) ? ITER_BITS : W
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // pixel requests
  input  wire                   start,
  output logic                  busy,
  input  wire  [PIXEL_BITS-1:0] in_pixel_x,
  input  wire  [PIXEL_BITS-1:0] in_pixel_y,
  // results
  output logic                  out_strobe,
  output logic [ITER_BITS-1:0]  out_iteration_count,
  output logic [2:0]            out_palette_index,
  // configuration writes
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_index,
  input  wire  [CW-1:0]         cfg_wdata
);
  import mbe_pkg::*;

  // register file
  logic [ITER_BITS-1:0] max_iter_r;
  logic signed [W-1:0]  org_re_r, org_im_r;
  logic [FRAC_BITS-1:0] step_r;

  logic                 hold;
  logic                 c_vld, c_take;
  logic signed [W-1:0]  c_re, c_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= ITER_BITS'(MAX_ITER_RST);
      org_re_r   <= W'(clamp_word(ORG_RE_RST, W));
      org_im_r   <= W'(clamp_word(ORG_IM_RST, W));
      step_r     <= FRAC_BITS'(STEP_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_BITS-1:0];
        REG_ORG_RE:   org_re_r   <= cfg_wdata[W-1:0];
        REG_ORG_IM:   org_im_r   <= cfg_wdata[W-1:0];
        REG_STEP:     step_r     <= cfg_wdata[FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front end: pixel -> c, two stages plus a holding slot
  mbe_coord #(
    .PIXEL_BITS(PIXEL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (start),
    .req_x   (in_pixel_x),
    .req_y   (in_pixel_y),
    .req_hold(hold),
    .org_re  (org_re_r),
    .org_im  (org_im_r),
    .step    (step_r),
    .c_vld   (c_vld),
    .c_re    (c_re),
    .c_im    (c_im),
    .c_take  (c_take)
  );

  // busy only while the first front stage cannot move on
  assign busy = hold;

  // iteration ring, results registered inside
  mbe_ring #(
    .FRAC_BITS(FRAC_BITS),
    .ITER_BITS(ITER_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .max_iter(max_iter_r),
    .c_vld   (c_vld),
    .c_re    (c_re),
    .c_im    (c_im),
    .c_take  (c_take),
    .res_vld (out_strobe),
    .res_cnt (out_iteration_count),
    .res_pal (out_palette_index)
  );

  // palette index is a residue mod 7
  a_pal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_palette_index != 3'd7)
    else $error("palette index out of range");

  // zero count maps to palette zero
  a_pal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_iteration_count == '0) |-> out_palette_index == 3'd0)
    else $error("palette index does not match zero count");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

endmodule

`default_nettype wire

/* sim/mandelbrot_escape_time_tb.sv */
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  localparam int     FB      = 28;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam longint FOUR    = 64'sd4 <<< FB;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [9:0]  in_pixel_x;
  logic [9:0]  in_pixel_y;
  logic        out_strobe;
  logic [15:0] out_iteration_count;
  logic [2:0]  out_palette_index;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [31:0] cfg_wdata;

  mandelbrot_escape_time dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_strobe(out_strobe),
    .out_iteration_count(out_iteration_count),
    .out_palette_index(out_palette_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // One expected pixel result
  typedef struct {
    int unsigned cnt;
    int unsigned pal;
  } pix_result_t;

  // Directed row: register set, pixel, and an optional hand-computed count
  typedef struct {
    int unsigned lim;
    longint      ore;
    longint      oim;
    longint      stp;
    int unsigned x;
    int unsigned y;
    bit          known;
    int unsigned cnt;
  } pix_row_t;

  pix_result_t pending_px[$];
  int          errors;
  bit          idle_on;

  // Shadow copy of the register file
  int unsigned lim_r;
  longint      org_re_r;
  longint      org_im_r;
  longint      pitch_r;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #48_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint clip(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Pixel to complex coordinate; the product saturates before the add
  function automatic longint pixel_coord(longint org, int unsigned px);
    longint prod;
    prod = longint'(px) * pitch_r;
    if (prod > WORD_HI) prod = WORD_HI;
    return clip(org + prod);
  endfunction

  // Escape-time count for one pixel under the shadow registers.
  // Products floor via arithmetic shift; the cross term keeps one extra bit.
  function automatic int unsigned escape_count(int unsigned px, int unsigned py);
    longint cr, ci, zr, zi, rr, ii, ri;
    int unsigned n;
    cr = pixel_coord(org_re_r, px);
    ci = pixel_coord(org_im_r, py);
    zr = 0;
    zi = 0;
    n  = 0;
    while (n < lim_r) begin
      rr = (zr * zr) >>> FB;
      ii = (zi * zi) >>> FB;
      ri = (zr * zi) >>> (FB - 1);
      zr = clip(clip(rr - ii) + cr);
      zi = clip(clip(ri) + ci);
      if (((zr * zr) >>> FB) + ((zi * zi) >>> FB) > FOUR) break;
      n++;
    end
    return n;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_px.size() == 0) begin
        flag_mismatch("unexpected result, count", out_iteration_count, -1);
      end else begin
        e = pending_px.pop_front();
        if (out_iteration_count != e.cnt)
          flag_mismatch("iteration_count", out_iteration_count, e.cnt);
        if (out_palette_index != e.pal)
          flag_mismatch("palette_index", out_palette_index, e.pal);
      end
    end
  end

  // Wait until every request has come back, plus a little margin
  task automatic drain();
    start <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram all four registers while the block is idle
  task automatic load_regs(int unsigned lim, longint ore, longint oim, longint stp);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_ITER;
    cfg_wdata <= 32'(lim & 16'hFFFF);
    @(posedge clk);
    cfg_index <= REG_ORG_RE;
    cfg_wdata <= 32'(ore);
    @(posedge clk);
    cfg_index <= REG_ORG_IM;
    cfg_wdata <= 32'(oim);
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_wdata <= 32'(stp & 28'hFFFFFFF);
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_r    = lim & 16'hFFFF;
    org_re_r = clip(ore);
    org_im_r = clip(oim);
    pitch_r  = stp & 28'hFFFFFFF;
    @(posedge clk);
  endtask

  // Issue one pixel request; start stays high on return so back-to-back
  // requests need no extra cycle. Callers lower it via drain().
  task automatic send_pixel(int unsigned x, int unsigned y, bit known, int unsigned cnt);
    pix_result_t e;
    if (idle_on && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start      <= 1'b1;
    in_pixel_x <= 10'(x);
    in_pixel_y <= 10'(y);
    do @(posedge clk); while (busy);
    e.cnt = known ? cnt : escape_count(x, y);
    e.pal = e.cnt % 7;
    pending_px.push_back(e);
  endtask

  initial begin
    pix_row_t    rows[$];
    pix_row_t    r;
    int unsigned sent;
    int unsigned burst;
    int unsigned lim;
    longint      ore, oim, stp;

    errors     = 0;
    idle_on    = 1'b1;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_MAX_ITER;
    cfg_wdata  = '0;
    lim_r      = MAX_ITER_RST;
    org_re_r   = ORG_RE_RST;
    org_im_r   = ORG_IM_RST;
    pitch_r    = STEP_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed set. First rows run on reset values.
    // Pixel zero sits at -3-1.2i and escapes on the first update.
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 0, 0, 1, 0});
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 1023, 1023, 0, 0});
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 375, 150, 0, 0});
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 1023, 0, 0, 0});
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 0, 1023, 0, 0});
    rows.push_back('{MAX_ITER_RST, ORG_RE_RST, ORG_IM_RST, STEP_RST, 250, 120, 0, 0});
    // zero limit runs nothing
    rows.push_back('{0, 0, 0, 0, 0, 0, 1, 0});
    rows.push_back('{0, 0, 0, 0, 1023, 1023, 1, 0});
    // c = 0 never escapes: count equals the limit
    rows.push_back('{1, 0, 0, 0, 5, 9, 1, 1});
    rows.push_back('{65535, 0, 0, 0, 1023, 0, 1, 65535});
    // c = -2 hovers at |z|^2 == 4, which is not an escape
    rows.push_back('{50, -64'sd536870912, 0, 0, 77, 33, 1, 50});
    // coordinate saturation at both ends of the word
    rows.push_back('{20, WORD_HI, WORD_HI, 64'hFFFFFFF, 1023, 1023, 0, 0});
    rows.push_back('{20, WORD_LO, WORD_LO, 64'hFFFFFFF, 1023, 1023, 0, 0});
    rows.push_back('{20, WORD_LO, WORD_LO, 64'hFFFFFFF, 0, 0, 0, 0});
    rows.push_back('{20, WORD_LO, WORD_HI, 64'hFFFFFFF, 512, 1, 0, 0});
    // tiny pitch near the edge of the set, long runs
    rows.push_back('{300, -64'sd201326592, 64'sd174483046, 1, 1023, 1023, 0, 0});
    rows.push_back('{300, -64'sd201326592, 64'sd174483046, 1, 0, 0, 0, 0});
    // big iterates that saturate z before escape is seen
    rows.push_back('{40, 64'sd510027366, -64'sd510027366, 0, 3, 3, 0, 0});
    rows.push_back('{40, WORD_LO, 0, 0, 3, 3, 0, 0});

    foreach (rows[i]) begin
      r = rows[i];
      if (r.lim != lim_r || clip(r.ore) != org_re_r || clip(r.oim) != org_im_r ||
          r.stp != pitch_r)
        load_regs(r.lim, r.ore, r.oim, r.stp);
      send_pixel(r.x, r.y, r.known, r.cnt);
    end

    // Random phases: mostly short limits over the interesting region,
    // now and then whole-word origins and pitches.
    sent = 0;
    while (sent < 600) begin
      lim = ($urandom_range(99) < 80) ? $urandom_range(1, 48) : $urandom_range(49, 400);
      if ($urandom_range(99) < 70) begin
        ore = longint'($urandom_range(0, 805306368)) - 64'sd671088640;
        oim = longint'($urandom_range(0, 805306368)) - 64'sd402653184;
      end else begin
        ore = longint'(signed'($urandom));
        oim = longint'(signed'($urandom));
      end
      stp = ($urandom_range(99) < 70) ? longint'($urandom_range(0, 1 << 20))
                                      : longint'($urandom & 32'hFFFFFFF);
      load_regs(lim, ore, oim, stp);
      burst = $urandom_range(40, 80);
      repeat (burst) begin
        // stretch with back-to-back requests
        idle_on = !(sent >= 250 && sent < 400);
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0);
        sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
